FILE: rtl/sgwe_pkg.sv
// sgwe_pkg: shared constants, axis types and per-axis helper functions
// for the strided grid window extractor; depends on nothing else
package sgwe_pkg;

  localparam int unsigned AXIS_BITS    = 16;
  localparam int unsigned ELEMENT_BITS = 64;
  localparam int unsigned SLOT_BITS    = 16;
  localparam int unsigned DATA_W       = 64;
  localparam int unsigned INDEX_W      = 48;
  localparam int unsigned WINDOW_W     = 64;
  localparam int unsigned CFG_IDX_W    = 2;

  localparam logic [DATA_W-1:0] ELEM_MASK = {DATA_W{1'b1}} >> (DATA_W - ELEMENT_BITS);
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 64'h0001_0000_0000_0001;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_I_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_J_WINDOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_K_WINDOW = 2'd2;

  typedef logic [AXIS_BITS-1:0] axis_val_t;
  typedef logic [AXIS_BITS:0]   axis_wide_t;

  typedef struct packed {
    axis_val_t ext;
    axis_val_t trim_lo;
    axis_val_t trim_hi;
    axis_val_t skip;
  } axis_cfg_t;

  typedef struct packed {
    axis_val_t pos;
    axis_val_t phase;
  } axis_cnt_t;

  function automatic axis_cfg_t axis_unpack(logic [WINDOW_W-1:0] w);
    axis_cfg_t a;
    a.ext     = w[0*SLOT_BITS +: AXIS_BITS];
    a.trim_lo = w[1*SLOT_BITS +: AXIS_BITS];
    a.trim_hi = w[2*SLOT_BITS +: AXIS_BITS];
    a.skip    = w[3*SLOT_BITS +: AXIS_BITS];
    return a;
  endfunction

  function automatic logic axis_ok(axis_cfg_t a);
    axis_wide_t trims;
    logic ok;
    trims = {1'b0, a.trim_lo} + {1'b0, a.trim_hi};
    ok = 1'b1;
    if (a.ext == '0 || a.skip == '0) ok = 1'b0;
    if (a.ext == axis_val_t'(1) &&
        (a.skip != axis_val_t'(1) || a.trim_lo != '0 || a.trim_hi != '0)) ok = 1'b0;
    if (trims >= {1'b0, a.ext}) ok = 1'b0;
    return ok;
  endfunction

  // on the trimmed window and the skip grid
  function automatic logic axis_keep(axis_cfg_t a, axis_cnt_t c);
    axis_val_t lim;
    lim = a.ext - a.trim_hi;
    return (c.pos >= a.trim_lo) && (c.pos < lim) && (c.phase == '0);
  endfunction

  // last kept position on this axis
  function automatic logic axis_last(axis_cfg_t a, axis_cnt_t c);
    axis_wide_t sum;
    axis_val_t  lim;
    sum = {1'b0, c.pos} + {1'b0, a.skip};
    lim = a.ext - a.trim_hi;
    return sum >= {1'b0, lim};
  endfunction

  function automatic logic axis_wraps(axis_cfg_t a, axis_cnt_t c);
    axis_wide_t nxt;
    nxt = {1'b0, c.pos} + axis_wide_t'(1);
    return nxt >= {1'b0, a.ext};
  endfunction

  function automatic axis_cnt_t axis_step(axis_cfg_t a, axis_cnt_t c);
    axis_cnt_t  r;
    axis_wide_t ph;
    ph = {1'b0, c.phase} + axis_wide_t'(1);
    r  = c;
    if (axis_wraps(a, c)) begin
      r.pos   = '0;
      r.phase = '0;
    end else begin
      if (c.pos >= a.trim_lo) begin
        r.phase = (ph >= {1'b0, a.skip}) ? '0 : ph[AXIS_BITS-1:0];
      end
      r.pos = c.pos + axis_val_t'(1);
    end
    return r;
  endfunction

endpackage

FILE: rtl/strided_grid_window_extractor_unit.sv
// strided_grid_window_extractor_unit: crops and decimates an I-fastest 3-axis
// element stream; uses sgwe_pkg for types, constants and axis helpers
//
//  channel  | dir | handshake                         | payload
//  ---------+-----+-----------------------------------+--------------------------------
//  s_axis   | in  | s_axis_tvalid / s_axis_tready     | tdata = element_data
//  m_axis   | out | m_axis_tvalid / m_axis_tready     | tdata, tlast, tuser (see ports)
//  cfg      | in  | cfg_valid_i / cfg_ready_o         | cfg_index_i, cfg_data_i
//
// one word per clock in unless m_axis holds back the full output register, zero or one word out
// per input word, shown on m_axis in the cycle after its input word is taken; a single output
// register sits between the decision logic and m_axis; a new word is taken whenever that
// register is empty or being emptied in the same cycle; reset clears position and phase
// counters, kept count and output valid, and loads every axis window with extent 1, skip 1
// cfg_ready_o is always high; writes are expected only while the stream is idle
module strided_grid_window_extractor_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [sgwe_pkg::DATA_W-1:0]    s_axis_tdata,   // [63:0] element_data
  // output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [sgwe_pkg::DATA_W+sgwe_pkg::INDEX_W-1:0]
                                         m_axis_tdata,   // [63:0] kept_data,
                                                         // [111:64] dest_index
  output logic                           m_axis_tlast,   // last_kept
  output logic                           m_axis_tuser,   // config_error
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sgwe_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [sgwe_pkg::WINDOW_W-1:0]  cfg_data_i
);

  // axis settings, unpacked and trimmed to the axis width
  sgwe_pkg::axis_cfg_t cfg_i_q, cfg_j_q, cfg_k_q;

  // source counters
  sgwe_pkg::axis_cnt_t cnt_i_q, cnt_j_q, cnt_k_q;
  sgwe_pkg::axis_cnt_t cnt_i_d, cnt_j_d, cnt_k_d;
  logic [sgwe_pkg::INDEX_W-1:0] kept_cnt_q, kept_cnt_d;

  // output register
  logic                         out_vld_q, out_vld_d;
  logic [sgwe_pkg::DATA_W-1:0]  out_data_q, out_data_d;
  logic [sgwe_pkg::INDEX_W-1:0] out_idx_q, out_idx_d;
  logic                         out_last_q, out_last_d;
  logic                         out_err_q, out_err_d;

  logic in_acc;
  logic cfg_good;
  logic keep, last;
  logic wrap_i, wrap_j, wrap_k;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_vld_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_idx_q, out_data_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_err_q;

  // decision and counter advance for the word at the input
  always_comb begin
    cfg_good = sgwe_pkg::axis_ok(cfg_i_q) && sgwe_pkg::axis_ok(cfg_j_q) &&
               sgwe_pkg::axis_ok(cfg_k_q);
    keep = sgwe_pkg::axis_keep(cfg_i_q, cnt_i_q) && sgwe_pkg::axis_keep(cfg_j_q, cnt_j_q) &&
           sgwe_pkg::axis_keep(cfg_k_q, cnt_k_q);
    last = sgwe_pkg::axis_last(cfg_i_q, cnt_i_q) && sgwe_pkg::axis_last(cfg_j_q, cnt_j_q) &&
           sgwe_pkg::axis_last(cfg_k_q, cnt_k_q);
    wrap_i = sgwe_pkg::axis_wraps(cfg_i_q, cnt_i_q);
    wrap_j = sgwe_pkg::axis_wraps(cfg_j_q, cnt_j_q);
    wrap_k = sgwe_pkg::axis_wraps(cfg_k_q, cnt_k_q);

    cnt_i_d    = cnt_i_q;
    cnt_j_d    = cnt_j_q;
    cnt_k_d    = cnt_k_q;
    kept_cnt_d = kept_cnt_q;

    out_vld_d  = out_vld_q && !m_axis_tready;
    out_data_d = out_data_q;
    out_idx_d  = out_idx_q;
    out_last_d = out_last_q;
    out_err_d  = out_err_q;

    if (in_acc) begin
      if (!cfg_good) begin
        // bad settings: error word, counters frozen
        out_vld_d  = 1'b1;
        out_data_d = '0;
        out_idx_d  = '0;
        out_last_d = 1'b0;
        out_err_d  = 1'b1;
      end else begin
        if (keep) begin
          out_vld_d  = 1'b1;
          out_data_d = s_axis_tdata & sgwe_pkg::ELEM_MASK;
          out_idx_d  = kept_cnt_q;
          out_last_d = last;
          out_err_d  = 1'b0;
          kept_cnt_d = kept_cnt_q + sgwe_pkg::INDEX_W'(1);
        end
        // i advances every word, j on i wrap, k on j wrap
        cnt_i_d = sgwe_pkg::axis_step(cfg_i_q, cnt_i_q);
        if (wrap_i) begin
          cnt_j_d = sgwe_pkg::axis_step(cfg_j_q, cnt_j_q);
          if (wrap_j) begin
            cnt_k_d = sgwe_pkg::axis_step(cfg_k_q, cnt_k_q);
            // end of volume restarts the dense index
            if (wrap_k) kept_cnt_d = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_i_q    <= sgwe_pkg::axis_unpack(sgwe_pkg::WINDOW_RESET);
      cfg_j_q    <= sgwe_pkg::axis_unpack(sgwe_pkg::WINDOW_RESET);
      cfg_k_q    <= sgwe_pkg::axis_unpack(sgwe_pkg::WINDOW_RESET);
      cnt_i_q    <= '0;
      cnt_j_q    <= '0;
      cnt_k_q    <= '0;
      kept_cnt_q <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          sgwe_pkg::REG_I_WINDOW: cfg_i_q <= sgwe_pkg::axis_unpack(cfg_data_i);
          sgwe_pkg::REG_J_WINDOW: cfg_j_q <= sgwe_pkg::axis_unpack(cfg_data_i);
          sgwe_pkg::REG_K_WINDOW: cfg_k_q <= sgwe_pkg::axis_unpack(cfg_data_i);
          default: ;
        endcase
      end
      cnt_i_q    <= cnt_i_d;
      cnt_j_q    <= cnt_j_d;
      cnt_k_q    <= cnt_k_d;
      kept_cnt_q <= kept_cnt_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // payload of the output register, no reset
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_idx_q  <= out_idx_d;
    out_last_q <= out_last_d;
    out_err_q  <= out_err_d;
  end

endmodule
